>>> rtl/gtfd_pkg.sv
package gtfd_pkg;

    // Fixed field widths of the register file and of the Q0.16 arithmetic.
    localparam int GAIN_W  = 16;
    localparam int FB_W    = 16;
    localparam int STEP_W  = 32;
    localparam int LEN_W   = 15;
    localparam int PHASE_W = 32;
    localparam int FRAC_W  = 16;
    // A Q0.16 coefficient that can reach 1.0 needs one more bit.
    localparam int COEF_W  = FRAC_W + 1;

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    localparam logic [GAIN_W-1:0]  GAIN_RESET         = 16'd32768;
    localparam logic [FB_W-1:0]    FEEDBACK_RESET     = 16'd16384;
    localparam logic               LFO_ENABLE_RESET   = 1'b1;
    localparam logic [STEP_W-1:0]  LFO_STEP_RESET     = 32'd8948;
    localparam logic [LEN_W-1:0]   DELAY_LENGTH_RESET = 15'd12000;

    // pi/2 in Q30 and the number of Taylor terms used to build the sine table.
    localparam logic [63:0] PI_HALF_Q30  = 64'd1686629713;
    localparam int          TAYLOR_TERMS = 8;

    typedef enum logic [2:0] {
        REG_GAIN         = 3'd0,
        REG_FEEDBACK     = 3'd1,
        REG_LFO_ENABLE   = 3'd2,
        REG_LFO_STEP     = 3'd3,
        REG_DELAY_LENGTH = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain;
        logic [FB_W-1:0]    feedback;
        logic               lfo_enable;
        logic [STEP_W-1:0]  lfo_step;
        logic [LEN_W-1:0]   delay_length;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic scale;
        logic trem;
        logic feed;
        logic load_out;
    } dp_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_TREM,
        ST_FEED,
        ST_HOLD
    } ctrl_state_t;

    // One quarter-wave sine entry in Q0.16, sin(pi/2 * idx / 2^tbl_bits).
    // Evaluated only while elaborating the constant table.
    function automatic logic [COEF_W-1:0] quarter_sine(input int unsigned idx,
                                                       input int unsigned tbl_bits);
        logic [63:0] a;
        logic [63:0] term;
        logic [63:0] q;
        longint      sum;
        a = (PI_HALF_Q30 * 64'(idx)) >> tbl_bits;
        term = a;
        sum = longint'(a);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = (term * a) >> 30;
            term = (term * a) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
            begin
                sum = sum - longint'(term);
            end
            else
            begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (64'(sum) + 64'd8192) >> 14;
        if (q > 64'd65536)
        begin
            q = 64'd65536;
        end
        return q[COEF_W-1:0];
    endfunction

endpackage

>>> rtl/gtfd_ram.sv
module gtfd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/gtfd_ctrl.sv
module gtfd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output gtfd_pkg::dp_cmd_t cmd
);

    gtfd_pkg::ctrl_state_t state_reg;
    gtfd_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  slot_free;

    // The output register can take a new result when empty or emptied now.
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gtfd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gtfd_pkg::ST_SCALE;
                end
            end
            gtfd_pkg::ST_SCALE: state_next = gtfd_pkg::ST_TREM;
            gtfd_pkg::ST_TREM:  state_next = gtfd_pkg::ST_FEED;
            gtfd_pkg::ST_FEED:
            begin
                state_next = slot_free ? gtfd_pkg::ST_IDLE : gtfd_pkg::ST_HOLD;
            end
            gtfd_pkg::ST_HOLD:
            begin
                if (slot_free)
                begin
                    state_next = gtfd_pkg::ST_IDLE;
                end
            end
            default: state_next = gtfd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gtfd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            gtfd_pkg::ST_SCALE: cmd.scale = 1'b1;
            gtfd_pkg::ST_TREM:  cmd.trem = 1'b1;
            gtfd_pkg::ST_FEED:
            begin
                cmd.feed = 1'b1;
                cmd.load_out = slot_free;
            end
            gtfd_pkg::ST_HOLD:  cmd.load_out = slot_free;
            default:            cmd = '0;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtfd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted request always passes through the scale and tremolo steps to the write-back step.
    a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##3 (state_reg == gtfd_pkg::ST_FEED))
        else $error("write-back step not reached three cycles after a request");

    // Waiting for the output only happens while an older result is still held.
    a_hold_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gtfd_pkg::ST_HOLD) |-> out_valid_reg)
        else $error("hold state entered with an empty output register");

    // A loaded result is presented on the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

>>> rtl/gtfd_dp.sv
module gtfd_dp #(
    parameter int DELAY_DEPTH     = 16384,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gtfd_pkg::dp_cmd_t             cmd,
    input  gtfd_pkg::cfg_t                cfg,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int SB      = SAMPLE_BITS;
    localparam int STB     = SINE_TABLE_BITS;
    localparam int AW      = $clog2(DELAY_DEPTH);
    localparam int FILL_W  = AW + 1;
    localparam int CMP_W   = (FILL_W > gtfd_pkg::LEN_W) ? FILL_W : gtfd_pkg::LEN_W;
    localparam int TBL_N   = 1 << STB;
    localparam int ROM_AW  = STB + 1;
    localparam int COEF_W  = gtfd_pkg::COEF_W;
    localparam int FRAC_W  = gtfd_pkg::FRAC_W;
    localparam int PHASE_W = gtfd_pkg::PHASE_W;
    localparam int MA_W    = SB + 1;
    localparam int MB_W    = COEF_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int LANES   = 2;

    localparam logic signed [PROD_W-1:0] SMAX_P = PROD_W'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic signed [PROD_W-1:0] SMIN_P = ~SMAX_P;
    localparam logic [COEF_W:0]          UNITY  = (COEF_W + 1)'(1 << FRAC_W);

    function automatic logic [SB-1:0] sat_sb(input logic signed [PROD_W-1:0] v);
        logic [SB-1:0] r;
        if (v > SMAX_P)
        begin
            r = SMAX_P[SB-1:0];
        end
        else if (v < SMIN_P)
        begin
            r = SMIN_P[SB-1:0];
        end
        else
        begin
            r = v[SB-1:0];
        end
        return r;
    endfunction

    // Quarter-wave sine table, built while elaborating.
    logic [COEF_W-1:0] sine_rom [TBL_N+1];
    for (genvar g = 0; g <= TBL_N; g++)
    begin : g_rom
        localparam logic [COEF_W-1:0] ENTRY = gtfd_pkg::quarter_sine(g, STB);
        assign sine_rom[g] = ENTRY;
    end

    logic signed [SB-1:0]    in_reg [LANES];
    logic signed [SB-1:0]    entry_reg [LANES];
    logic signed [SB-1:0]    scaled_reg [LANES];
    logic signed [SB-1:0]    y_reg [LANES];
    logic signed [SB:0]      sum_reg [LANES];
    logic signed [SB-1:0]    out_reg [LANES];
    logic [COEF_W-1:0]       rom_data_reg;
    logic                    quad_neg_reg;
    logic [COEF_W-1:0]       factor_reg;
    logic                    entry_ok_reg;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           pos_next;
    logic [FILL_W-1:0]       fill_reg;
    logic [FILL_W-1:0]       fill_next;
    logic [PHASE_W-1:0]      phase_reg;

    logic [STB-1:0]          sine_idx;
    logic [ROM_AW-1:0]       rom_addr;
    logic [COEF_W:0]         factor_sum;
    logic signed [MA_W-1:0]  mul_a [LANES];
    logic signed [MB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod [LANES];
    logic signed [PROD_W-1:0] prod_q [LANES];
    logic signed [SB:0]      out_sum [LANES];
    logic [LANES*SB-1:0]     ram_wdata;
    logic [LANES*SB-1:0]     ram_rdata;
    logic [CMP_W-1:0]        len_raw;
    logic [CMP_W-1:0]        len_eff;
    logic [CMP_W-1:0]        pos_inc;

    // Sine lookup address: mirror the index in the odd quadrants.
    assign sine_idx = phase_reg[PHASE_W-3 -: STB];
    assign rom_addr = phase_reg[PHASE_W-2] ? (ROM_AW'(TBL_N) - {1'b0, sine_idx})
                                           : {1'b0, sine_idx};

    // (1 + s) / 2 with s negated in the second half of the LFO cycle.
    assign factor_sum = quad_neg_reg ? (UNITY - {1'b0, rom_data_reg})
                                     : (UNITY + {1'b0, rom_data_reg});

    // One multiplier per channel, reused for gain, tremolo and feedback.
    always_comb
    begin
        if (cmd.scale)
        begin
            mul_b = MB_W'(cfg.gain);
        end
        else if (cmd.trem)
        begin
            mul_b = MB_W'(factor_reg);
        end
        else
        begin
            mul_b = MB_W'(cfg.feedback);
        end
        for (int c = 0; c < LANES; c++)
        begin
            if (cmd.scale)
            begin
                mul_a[c] = {in_reg[c][SB-1], in_reg[c]};
            end
            else if (cmd.trem)
            begin
                mul_a[c] = {scaled_reg[c][SB-1], scaled_reg[c]};
            end
            else
            begin
                mul_a[c] = sum_reg[c];
            end
            prod[c] = mul_a[c] * mul_b;
            prod_q[c] = prod[c] >>> FRAC_W;
            out_sum[c] = {y_reg[c][SB-1], y_reg[c]} + {entry_reg[c][SB-1], entry_reg[c]};
            ram_wdata[c*SB +: SB] = sat_sb(prod_q[c]);
        end
    end

    // Effective delay length and position / fill count advance.
    always_comb
    begin
        len_raw = CMP_W'(cfg.delay_length);
        if (len_raw == '0)
        begin
            len_eff = CMP_W'(1);
        end
        else if (len_raw > CMP_W'(DELAY_DEPTH))
        begin
            len_eff = CMP_W'(DELAY_DEPTH);
        end
        else
        begin
            len_eff = len_raw;
        end
        pos_inc = CMP_W'(pos_reg) + CMP_W'(1);
        pos_next = (pos_inc >= len_eff) ? '0 : pos_inc[AW-1:0];
        fill_next = (FILL_W'(pos_reg) == fill_reg) ? (fill_reg + FILL_W'(1)) : fill_reg;
    end

    gtfd_ram #(
        .WIDTH(LANES * SB),
        .DEPTH(DELAY_DEPTH)
    ) u_delay_ram (
        .clk  (clk),
        .we   (cmd.feed),
        .waddr(pos_reg),
        .wdata(ram_wdata),
        .re   (cmd.capture),
        .raddr(pos_reg),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fill_reg <= '0;
            phase_reg <= '0;
        end
        else if (cmd.feed)
        begin
            pos_reg <= pos_next;
            fill_reg <= fill_next;
            if (cfg.lfo_enable)
            begin
                phase_reg <= phase_reg + cfg.lfo_step;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg[0] <= left_in;
            in_reg[1] <= right_in;
            rom_data_reg <= sine_rom[rom_addr];
            quad_neg_reg <= phase_reg[PHASE_W-1];
            entry_ok_reg <= (FILL_W'(pos_reg) < fill_reg);
        end
        if (cmd.scale)
        begin
            factor_reg <= factor_sum[COEF_W:1];
            for (int c = 0; c < LANES; c++)
            begin
                scaled_reg[c] <= prod_q[c][SB-1:0];
                entry_reg[c] <= entry_ok_reg ? ram_rdata[c*SB +: SB] : '0;
            end
        end
        if (cmd.trem)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                y_reg[c] <= cfg.lfo_enable ? prod_q[c][SB-1:0] : scaled_reg[c];
                sum_reg[c] <= {entry_reg[c][SB-1], entry_reg[c]}
                              + {scaled_reg[c][SB-1], scaled_reg[c]};
            end
        end
        if (cmd.load_out)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                out_reg[c] <= sat_sb({{(PROD_W-SB-1){out_sum[c][SB]}}, out_sum[c]});
            end
        end
    end

    assign left_out = out_reg[0];
    assign right_out = out_reg[1];

    // Entries below the fill count have been written; the position never skips past it.
    a_fill_covers_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg >= FILL_W'(pos_reg))
        else $error("delay position ran past the written region");

    // After a write-back the position lies inside the active delay length.
    a_pos_in_length: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.feed |=> (CMP_W'(pos_reg) < len_eff))
        else $error("delay position outside the active length");

endmodule

>>> rtl/gain_tremolo_feedback_delay.sv
// Gain, tremolo and feedback-delay echo for stereo audio frames.
//
// A request on the input channel (in_valid/in_ready) carries one stereo frame of
// signed samples. Each sample is scaled by the gain register, optionally shaped by
// a sine tremolo, and summed with the delay-line entry at the current position,
// which is then rewritten with the feedback-scaled sum. One result request leaves
// on the output channel (out_valid/out_ready) for every input request.
//
// Sequence: the controller accepts a frame and issues the delay RAM read, then
// walks the frame through three steps on a per-channel multiplier (gain, tremolo,
// feedback). The result is loaded into the output register once it is free, and
// only then is the next frame accepted; frames do not overlap.
// A finished result sits in an output register, so the next frame is taken while
// the receiver stalls; if the receiver still holds the older result when the next
// one is ready, the block waits with in_ready low until the output is taken.
//
// Reset restores all registers to their defaults, the position and LFO phase to
// zero, and makes the delay line read as silence. The delay RAM is not swept:
// a fill count marks the entries written so far, so frames are accepted right
// after reset. Registers sit on an APB port and may only be written while idle.
module gain_tremolo_feedback_delay #(
    parameter int DELAY_DEPTH     = 16384,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // APB register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gtfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gtfd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gtfd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Input frames
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    // Output frames
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       left_out,
    output logic signed [SAMPLE_BITS-1:0]       right_out
);

    gtfd_pkg::cfg_t     cfg_reg;
    gtfd_pkg::cfg_t     cfg_next;
    gtfd_pkg::dp_cmd_t  cmd;
    gtfd_pkg::reg_idx_t reg_idx;
    logic               cfg_write;

    // Registers are word aligned; the low address bits are ignored.
    assign reg_idx = gtfd_pkg::reg_idx_t'(paddr[gtfd_pkg::APB_ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                gtfd_pkg::REG_GAIN:
                    cfg_next.gain = pwdata[gtfd_pkg::GAIN_W-1:0];
                gtfd_pkg::REG_FEEDBACK:
                    cfg_next.feedback = pwdata[gtfd_pkg::FB_W-1:0];
                gtfd_pkg::REG_LFO_ENABLE:
                    cfg_next.lfo_enable = pwdata[0];
                gtfd_pkg::REG_LFO_STEP:
                    cfg_next.lfo_step = pwdata[gtfd_pkg::STEP_W-1:0];
                gtfd_pkg::REG_DELAY_LENGTH:
                    cfg_next.delay_length = pwdata[gtfd_pkg::LEN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read-back of the register selected by the address.
    always_comb
    begin
        unique case (reg_idx)
            gtfd_pkg::REG_GAIN:
                prdata = gtfd_pkg::APB_DATA_W'(cfg_reg.gain);
            gtfd_pkg::REG_FEEDBACK:
                prdata = gtfd_pkg::APB_DATA_W'(cfg_reg.feedback);
            gtfd_pkg::REG_LFO_ENABLE:
                prdata = gtfd_pkg::APB_DATA_W'(cfg_reg.lfo_enable);
            gtfd_pkg::REG_LFO_STEP:
                prdata = gtfd_pkg::APB_DATA_W'(cfg_reg.lfo_step);
            gtfd_pkg::REG_DELAY_LENGTH:
                prdata = gtfd_pkg::APB_DATA_W'(cfg_reg.delay_length);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain <= gtfd_pkg::GAIN_RESET;
            cfg_reg.feedback <= gtfd_pkg::FEEDBACK_RESET;
            cfg_reg.lfo_enable <= gtfd_pkg::LFO_ENABLE_RESET;
            cfg_reg.lfo_step <= gtfd_pkg::LFO_STEP_RESET;
            cfg_reg.delay_length <= gtfd_pkg::DELAY_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller sequences each frame; the datapath does the arithmetic and
    // owns the delay RAM, the sine table, the position and the LFO phase.
    gtfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .cmd      (cmd)
    );

    gtfd_dp #(
        .DELAY_DEPTH    (DELAY_DEPTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg_reg),
        .left_in  (left_in),
        .right_in (right_in),
        .left_out (left_out),
        .right_out(right_out)
    );

endmodule

>>> sim/echo_frame_checker.sv
module echo_frame_checker #(
    parameter int DELAY_DEPTH     = 16384,
    parameter int SAMPLE_BITS     = 24,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [gtfd_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gtfd_pkg::APB_DATA_W-1:0]     pwdata,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [SAMPLE_BITS-1:0]       left_in,
    input  logic signed [SAMPLE_BITS-1:0]       right_in,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [SAMPLE_BITS-1:0]       left_out,
    input  logic signed [SAMPLE_BITS-1:0]       right_out,
    output int                                  fail_count,
    output int                                  pending
);
    import gtfd_pkg::*;

    localparam int     TBL_N      = 1 << SINE_TABLE_BITS;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct {
        sample_t left;
        sample_t right;
    } frame_t;

    frame_t            frames_due[$];
    logic [COEF_W-1:0] quarter_wave [0:TBL_N];
    sample_t           echo_left  [0:DELAY_DEPTH-1];
    sample_t           echo_right [0:DELAY_DEPTH-1];
    int unsigned       echo_pos;
    logic [31:0]       lfo_acc;
    cfg_t              regs;

    // Quarter-wave sine in Q0.16 from a Q30 Taylor series, rounded and clamped.
    function automatic logic [COEF_W-1:0] sine_entry(input int unsigned i);
        longint unsigned ang;
        longint unsigned term;
        longint unsigned rounded;
        longint          acc;
        ang = (64'd1686629713 * longint'(i)) >> SINE_TABLE_BITS;
        term = ang;
        acc = longint'(ang);
        for (int k = 1; k <= 8; k++)
        begin
            term = (term * ang) >> 30;
            term = (term * ang) >> 30;
            term = term / longint'(4 * k * k + 2 * k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = (longint'(acc) + 8192) >> 14;
        if (rounded > 65536)
            rounded = 65536;
        return rounded[COEF_W-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i <= TBL_N; i++)
            quarter_wave[i] = sine_entry(i);
    end

    // Q0.16 product, rounded toward minus infinity.
    function automatic longint q16(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic sample_t clamp(input longint v);
        if (v > SAMPLE_MAX)
            return sample_t'(SAMPLE_MAX);
        if (v < SAMPLE_MIN)
            return sample_t'(SAMPLE_MIN);
        return sample_t'(v);
    endfunction

    // Tremolo factor (1 + sin) / 2 in Q0.16 for the given phase.
    function automatic longint trem_gain(input logic [31:0] ph);
        int unsigned ix;
        longint      s;
        ix = ph[29 -: SINE_TABLE_BITS];
        case (ph[31:30])
            2'd0:    s = longint'(quarter_wave[ix]);
            2'd1:    s = longint'(quarter_wave[TBL_N - ix]);
            2'd2:    s = -longint'(quarter_wave[ix]);
            default: s = -longint'(quarter_wave[TBL_N - ix]);
        endcase
        return (65536 + s) >>> 1;
    endfunction

    // One channel: returns the output sample and rewrites its delay entry.
    function automatic sample_t voice(input sample_t x, input longint tf,
                                      inout sample_t entry);
        longint scaled;
        longint y;
        scaled = q16(longint'(x), longint'(regs.gain));
        y = regs.lfo_enable ? q16(scaled, tf) : scaled;
        y = y + longint'(entry);
        entry = clamp(q16(longint'(entry) + scaled, longint'(regs.feedback)));
        return clamp(y);
    endfunction

    function automatic void take_frame(input sample_t l, input sample_t r);
        int unsigned span;
        longint      tf;
        frame_t      want;
        span = regs.delay_length;
        if (span == 0)
            span = 1;
        if (span > DELAY_DEPTH)
            span = DELAY_DEPTH;
        if (echo_pos >= DELAY_DEPTH)
            echo_pos = 0;
        tf = trem_gain(lfo_acc);
        want.left  = voice(l, tf, echo_left[echo_pos]);
        want.right = voice(r, tf, echo_right[echo_pos]);
        frames_due.push_back(want);
        if (regs.lfo_enable)
            lfo_acc = lfo_acc + regs.lfo_step;
        echo_pos++;
        if (echo_pos >= span)
            echo_pos = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            regs.gain         = GAIN_RESET;
            regs.feedback     = FEEDBACK_RESET;
            regs.lfo_enable   = LFO_ENABLE_RESET;
            regs.lfo_step     = LFO_STEP_RESET;
            regs.delay_length = DELAY_LENGTH_RESET;
            for (int i = 0; i < DELAY_DEPTH; i++)
            begin
                echo_left[i]  = '0;
                echo_right[i] = '0;
            end
            echo_pos = 0;
            lfo_acc = '0;
            frames_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_GAIN:         regs.gain         = pwdata[GAIN_W-1:0];
                    REG_FEEDBACK:     regs.feedback     = pwdata[FB_W-1:0];
                    REG_LFO_ENABLE:   regs.lfo_enable   = pwdata[0];
                    REG_LFO_STEP:     regs.lfo_step     = pwdata[STEP_W-1:0];
                    REG_DELAY_LENGTH: regs.delay_length = pwdata[LEN_W-1:0];
                    default:          ;
                endcase
            end
            if (in_valid && in_ready)
                take_frame(left_in, right_in);
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: result with none expected, left %0d right %0d",
                             $time, left_out, right_out);
                    fail_count++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (left_out !== want.left)
                    begin
                        $display("%0t: left_out expected %0d, got %0d",
                                 $time, want.left, left_out);
                        fail_count++;
                    end
                    if (right_out !== want.right)
                    begin
                        $display("%0t: right_out expected %0d, got %0d",
                                 $time, want.right, right_out);
                        fail_count++;
                    end
                end
            end
        end
        pending = frames_due.size();
    end

endmodule

>>> sim/gain_tremolo_feedback_delay_test.sv
module gain_tremolo_feedback_delay_test;
    import gtfd_pkg::*;

    localparam int DELAY_DEPTH     = 16384;
    localparam int SAMPLE_BITS     = 24;
    localparam int SINE_TABLE_BITS = 10;
    // Number of random stereo frames sent after the directed part.
    localparam int RANDOM_FRAMES   = 1550;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t FULL_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam sample_t FULL_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    sample_t               left_in;
    sample_t               right_in;
    logic                  out_valid;
    logic                  out_ready;
    sample_t               left_out;
    sample_t               right_out;

    // When calm is set, neither the sender nor the receiver inserts idle cycles.
    logic                  calm;
    int                    fail_count;
    int                    pending;
    int                    sent;
    int                    phase_no;
    int                    burst;

    gain_tremolo_feedback_delay #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    // The checker watches both channels and the register port, predicts every
    // result and compares it; this module only makes stimulus.
    echo_frame_checker #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_echo_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .left_in    (left_in),
        .right_in   (right_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .left_out   (left_out),
        .right_out  (right_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run, even with heavy stalling
    // on both sides.
    initial
    begin
        #3000000;
        $display("FAILED: results differ");
        $finish;
    end

    // The receiver drops ready with about 37 percent probability, decided anew at
    // every falling edge, except during the calm phase.
    always @(negedge clk)
    begin
        out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 37);
    end

    // One register write: a setup cycle, an access cycle, then a free cycle so
    // that back-to-back writes never assign psel twice in one time step.
    task automatic apb_write(input reg_idx_t r, input logic [APB_DATA_W-1:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {r, 2'b00};
        pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // Sends one frame request. Called at a falling edge and returns at one.
    // Idle cycles come first, each with about 37 percent probability, so the
    // gaps land on every stage of the block's frame sequence.
    task automatic send_frame(input sample_t l, input sample_t r);
        while (!calm && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in <= l;
        right_in <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers may only change while the block is idle, so wait for every
    // outstanding result and then for the pipeline to drain.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Samples lean toward the rails and near zero so that saturation and
    // rounding of negative products both show up often.
    function automatic sample_t pick_sample();
        sample_t v;
        case ($urandom_range(0, 9))
            0:       v = FULL_POS;
            1:       v = FULL_NEG;
            2:       v = sample_t'(int'($urandom_range(0, 511)) - 256);
            default: v = sample_t'($urandom);
        endcase
        return v;
    endfunction

    // A fresh setting of every register, with the extremes well represented.
    // Most delay lengths are short so that the echo path wraps and feeds back
    // many times; zero and lengths beyond the store depth are included.
    task automatic program_random();
        logic [APB_DATA_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        apb_write(REG_GAIN, v);
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 65535;
            default: v = $urandom_range(0, 65535);
        endcase
        apb_write(REG_FEEDBACK, v);
        apb_write(REG_LFO_ENABLE, $urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = 32'hFFFF_FFFF;
            2:       v = $urandom_range(0, 65535);
            default: v = $urandom;
        endcase
        apb_write(REG_LFO_STEP, v);
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 1;
            2:       v = DELAY_DEPTH;
            3:       v = 32767;
            4:       v = $urandom_range(DELAY_DEPTH + 1, 32767);
            5:       v = $urandom_range(2, DELAY_DEPTH);
            default: v = $urandom_range(2, 48);
        endcase
        apb_write(REG_DELAY_LENGTH, v);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        left_in = '0;
        right_in = '0;
        calm = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of all registers, with rail and near-zero samples.
        send_frame(FULL_POS, FULL_POS);
        send_frame(FULL_NEG, FULL_NEG);
        send_frame(0, 0);
        send_frame(-1, 1);
        send_frame(FULL_POS, FULL_NEG);
        send_frame(1, -1);

        // Full gain and full feedback on a one-entry delay line with the LFO
        // off: the single entry and the outputs run into saturation both ways.
        settle();
        apb_write(REG_GAIN, 65535);
        apb_write(REG_FEEDBACK, 65535);
        apb_write(REG_LFO_ENABLE, 0);
        apb_write(REG_DELAY_LENGTH, 1);
        repeat (3) send_frame(FULL_POS, FULL_POS);
        repeat (3) send_frame(FULL_NEG, FULL_NEG);

        // A delay length of zero behaves as one; zero gain and feedback
        // leave only the stored echo on the output.
        settle();
        apb_write(REG_DELAY_LENGTH, 0);
        apb_write(REG_GAIN, 0);
        apb_write(REG_FEEDBACK, 0);
        send_frame(FULL_POS, FULL_NEG);
        send_frame(FULL_NEG, FULL_POS);

        // A quarter-turn step walks the phase through all four quadrants and
        // onto the peak of the table; the length above the depth is clipped.
        settle();
        apb_write(REG_GAIN, 65535);
        apb_write(REG_FEEDBACK, 32768);
        apb_write(REG_LFO_ENABLE, 1);
        apb_write(REG_LFO_STEP, 32'h4000_0000);
        apb_write(REG_DELAY_LENGTH, 32767);
        send_frame(FULL_POS, FULL_NEG);
        send_frame(FULL_POS, FULL_NEG);
        send_frame(FULL_NEG, FULL_POS);
        send_frame(FULL_POS, FULL_POS);
        settle();
        apb_write(REG_LFO_STEP, 32'hFFFF_FFFF);
        send_frame(FULL_NEG, FULL_NEG);

        // Shorten the line below the current position: the entry at that
        // position is still used once, then the position wraps to zero.
        settle();
        apb_write(REG_DELAY_LENGTH, 2);
        send_frame(FULL_POS, 12345);
        send_frame(-12345, FULL_NEG);
        send_frame(FULL_POS, FULL_POS);

        // Random phases, each with a fresh register setting. The fourth
        // phase runs with no idling on either side.
        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_FRAMES)
        begin
            settle();
            program_random();
            calm <= (phase_no == 3);
            burst = $urandom_range(60, 200);
            if (burst > RANDOM_FRAMES - sent)
                burst = RANDOM_FRAMES - sent;
            repeat (burst)
            begin
                send_frame(pick_sample(), pick_sample());
                sent++;
            end
            phase_no++;
        end

        settle();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

>>> gain_tremolo_feedback_delay.f
rtl/gtfd_pkg.sv
rtl/gtfd_ram.sv
rtl/gtfd_ctrl.sv
rtl/gtfd_dp.sv
rtl/gain_tremolo_feedback_delay.sv
sim/echo_frame_checker.sv
sim/gain_tremolo_feedback_delay_test.sv
